### hdl/ttu_pkg.sv
// shared constants, types and helpers of the tabu triple table unit
package ttu_pkg;

   // table geometry
   localparam int DEPTH  = 64;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int KEY_W  = 24;

   // field widths fixed by the beat format
   localparam int CAP_W  = 7;
   localparam int FILL_W = 7;
   localparam int BYTE_W = 8;

   // wide enough for head plus count and for the capacity register
   localparam int SUM_W  = ((CAP_W > CNT_W) ? CAP_W : CNT_W) + 1;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CAPACITY_IDX = 1'b0;

   // request modes
   localparam logic MODE_QUERY = 1'b0;
   localparam logic MODE_ADD   = 1'b1;

   // controller to datapath commands
   typedef struct packed {
      logic load_item;
      logic do_add;
      logic scan_en;
      logic load_out;
   } ttu_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic scan_done;
   } ttu_sts_type;

   // ring slot of a sum below twice the depth
   function automatic logic [ADDR_W-1:0] ring_wrap(input logic [SUM_W-1:0] x);
      logic [SUM_W-1:0] t;
      t = (x >= SUM_W'(DEPTH)) ? x - SUM_W'(DEPTH) : x;
      return t[ADDR_W-1:0];
   endfunction

endpackage

### hdl/ttu_if.sv
// request and response channel interfaces of the tabu triple table unit
interface ttu_req_if;
   import ttu_pkg::*;
   logic              valid;
   logic              ready;
   logic              mode;
   logic [BYTE_W-1:0] job_index;
   logic [BYTE_W-1:0] op_order;
   logic [BYTE_W-1:0] resource_index;

   modport source (output valid, mode, job_index, op_order, resource_index, input ready);
   modport sink   (input valid, mode, job_index, op_order, resource_index, output ready);
endinterface

interface ttu_rsp_if;
   import ttu_pkg::*;
   logic              valid;
   logic              ready;
   logic              hit;
   logic [FILL_W-1:0] fill_count;

   modport source (output valid, hit, fill_count, input ready);
   modport sink   (input valid, hit, fill_count, output ready);
endinterface

### hdl/ttu_ram.sv
// generic single write port ram with registered read
module ttu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/ttu_ctrl.sv
// sequencer of the tabu triple table unit
module ttu_ctrl
   import ttu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_mode,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output ttu_cmd_type cmd,
   input  ttu_sts_type sts
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_ADD    = 2'd1;
   localparam logic [1:0] ST_SCAN   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      cmd.load_item = accept;
      cmd.do_add    = 1'b0;
      cmd.scan_en   = 1'b0;
      cmd.load_out  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_mode == MODE_ADD) ? ST_ADD : ST_SCAN;
            end
         end
         ST_ADD: begin
            cmd.do_add = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_SCAN: begin
            cmd.scan_en = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response valid: set on load, cleared once the beat is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### hdl/ttu_dp.sv
// datapath of the tabu triple table unit: ring pointers, scan and result registers
module ttu_dp
   import ttu_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  ttu_cmd_type       cmd,
   output ttu_sts_type       sts,
   input  logic [KEY_W-1:0]  req_key,
   input  logic              cap_wr,
   input  logic [CAP_W-1:0]  cap_data,
   output logic [CAP_W-1:0]  capacity,
   output logic              rsp_hit,
   output logic [FILL_W-1:0] rsp_fill_count
);

   logic [CAP_W-1:0]  cap_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] head_ff, head_in;
   logic [KEY_W-1:0]  key_ff;
   logic [CNT_W-1:0]  idx_ff;
   logic [ADDR_W-1:0] ptr_ff;
   logic              pend_ff;
   logic              hit_ff, hit_in;
   logic              rsp_hit_ff;
   logic [FILL_W-1:0] rsp_fill_ff;

   logic [SUM_W-1:0]  cap_wide;
   logic [SUM_W-1:0]  eff_cap;
   logic [SUM_W-1:0]  count_wide;
   logic              full;
   logic [ADDR_W-1:0] wr_slot;
   logic              issue;
   logic [KEY_W-1:0]  rd_data;

   // capacity clamped to one .. depth
   assign cap_wide   = SUM_W'(cap_ff);
   assign count_wide = SUM_W'(count_ff);
   always_comb begin
      if (cap_wide == '0) begin
         eff_cap = SUM_W'(1);
      end else if (cap_wide > SUM_W'(DEPTH)) begin
         eff_cap = SUM_W'(DEPTH);
      end else begin
         eff_cap = cap_wide;
      end
   end

   // add: new entry always lands at head plus count, oldest entries drop when full
   assign full    = (count_wide >= eff_cap);
   assign wr_slot = ring_wrap(SUM_W'(head_ff) + count_wide);

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (cmd.do_add) begin
         if (full) begin
            head_in  = ring_wrap(SUM_W'(head_ff) + count_wide + SUM_W'(1) - eff_cap);
            count_in = CNT_W'(eff_cap);
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   // scan: one read issued a cycle, compare on the registered data
   assign issue         = cmd.scan_en && (idx_ff < count_ff) && !hit_ff;
   assign hit_in        = hit_ff || (pend_ff && (rd_data == key_ff));
   assign sts.scan_done = !issue && !pend_ff;

   ttu_ram #(
      .WIDTH(KEY_W),
      .DEPTH(DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.do_add),
      .wr_addr (wr_slot),
      .wr_data (key_ff),
      .rd_en   (issue),
      .rd_addr (ptr_ff),
      .rd_data (rd_data)
   );

   // table state and capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAP_RESET;
         count_ff <= '0;
         head_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         if (cap_wr) begin
            cap_ff <= cap_data;
         end
         count_ff <= count_in;
         head_ff  <= head_in;
         pend_ff  <= cmd.load_item ? 1'b0 : issue;
      end
   end

   // item, scan and result registers
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         key_ff <= req_key;
         idx_ff <= '0;
         ptr_ff <= head_ff;
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
         if (issue) begin
            idx_ff <= idx_ff + CNT_W'(1);
            ptr_ff <= ring_wrap(SUM_W'(ptr_ff) + SUM_W'(1));
         end
      end
      if (cmd.load_out) begin
         rsp_hit_ff  <= hit_ff;
         rsp_fill_ff <= FILL_W'(count_ff);
      end
   end

   assign capacity       = cap_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_fill_count = rsp_fill_ff;

endmodule

### hdl/tabu_triple_table_unit.sv
// Tabu triple table unit: a ring of up to DEPTH (job, operation order, resource)
// triples held in one memory. A request beat with mode add stores the triple,
// dropping the oldest entries once the fill count reaches the capacity register
// (zero counts as one, values above DEPTH as DEPTH); a beat with mode query
// answers hit when the triple matches a stored entry. Every request gives one
// response beat carrying hit (always 0 for an add) and the fill count after the
// item. Items are handled one at a time: an add passes an add and a finish state
// before its response is registered; a query scans the single read port of the
// memory one entry per cycle, stopping early on a hit.
// A finished response may wait in its output register while the next request
// is accepted. There is no clearing pass after reset. The capacity register
// (7 bits, reset 16) sits at byte address 0 of the configuration port and
// should be written only while the unit is idle.
module tabu_triple_table_unit
   import ttu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   ttu_req_if.sink               req_bus,
   ttu_rsp_if.source             rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   ttu_cmd_type      cmd;
   ttu_sts_type      sts;
   logic             cap_sel;
   logic             cap_wr;
   logic [CAP_W-1:0] capacity;

   // configuration port decode
   assign pready  = 1'b1;
   assign cap_sel = (paddr[CSR_ADDR_W-1] == CAPACITY_IDX);
   assign cap_wr  = psel && penable && pwrite && pready && cap_sel;
   assign prdata  = cap_sel ? CSR_DATA_W'(capacity) : '0;

   ttu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_mode  (req_bus.mode),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   ttu_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_key        ({req_bus.job_index, req_bus.op_order, req_bus.resource_index}),
      .cap_wr         (cap_wr),
      .cap_data       (pwdata[CAP_W-1:0]),
      .capacity       (capacity),
      .rsp_hit        (rsp_bus.hit),
      .rsp_fill_count (rsp_bus.fill_count)
   );

endmodule

### hdl/ttu_checker.sv
// port level checks of the tabu triple table unit and their bind
module ttu_checker
   import ttu_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_hit,
   input logic [FILL_W-1:0] rsp_fill_count
);

   // a stalled response beat stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat withdrawn while stalled");

   // a stalled response beat keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_hit) && $stable(rsp_fill_count))
      else $error("response payload changed while stalled");

   // one item in work at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an item is in work");

   // the fill count never passes the table depth
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_fill_count <= FILL_W'(DEPTH)))
      else $error("fill count beyond table depth");

   // nothing comes out right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response beat right after reset");

endmodule

bind tabu_triple_table_unit ttu_checker u_ttu_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_hit        (rsp_bus.hit),
   .rsp_fill_count (rsp_bus.fill_count)
);

### tb/tabu_triple_table_unit_test.sv
`timescale 1ns / 100ps
// self-checking testbench of the tabu triple table unit: directed rows, then random phases
module tabu_triple_table_unit_test;
   import ttu_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] CAP_ADDR   = CSR_ADDR_W'({CAPACITY_IDX, 2'b00});
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = CSR_ADDR_W'(4);
   localparam int STALL_LIMIT = 2000;
   localparam int TAIL_CYCLES = DEPTH + 16;
   localparam int RANDOM_CAP  = 128;
   localparam int RECENT_MAX  = 96;

   typedef struct packed {
      logic              hit;
      logic [FILL_W-1:0] fill;
   } outcome_type;

   typedef struct packed {
      logic        typed;
      outcome_type val;
   } pinned_type;

   typedef enum logic {ROW_ITEM, ROW_CAPACITY} row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      logic              mode;
      logic [BYTE_W-1:0] job;
      logic [BYTE_W-1:0] ord;
      logic [BYTE_W-1:0] res;
      logic [CAP_W-1:0]  cap;
      logic              typed;
      logic              hit;
      logic [FILL_W-1:0] fill;
   } row_type;

   // directed rows: kind, mode, job, order, resource, capacity, typed, hit, fill
   localparam row_type DIRECTED [27] = '{
      // empty table after reset, extremes of every field
      '{ROW_ITEM, MODE_QUERY, 8'h00, 8'h00, 8'h00, 7'd0, 1'b1, 1'b0, 7'd0},
      '{ROW_ITEM, MODE_QUERY, 8'hFF, 8'hFF, 8'hFF, 7'd0, 1'b1, 1'b0, 7'd0},
      '{ROW_ITEM, MODE_ADD,   8'h00, 8'h00, 8'h00, 7'd0, 1'b1, 1'b0, 7'd1},
      '{ROW_ITEM, MODE_ADD,   8'hFF, 8'hFF, 8'hFF, 7'd0, 1'b1, 1'b0, 7'd2},
      '{ROW_ITEM, MODE_QUERY, 8'h00, 8'h00, 8'h00, 7'd0, 1'b1, 1'b1, 7'd2},
      '{ROW_ITEM, MODE_QUERY, 8'hFF, 8'hFF, 8'hFF, 7'd0, 1'b1, 1'b1, 7'd2},
      // one part off by a single bit never hits
      '{ROW_ITEM, MODE_QUERY, 8'hFF, 8'hFF, 8'hFE, 7'd0, 1'b1, 1'b0, 7'd2},
      '{ROW_ITEM, MODE_QUERY, 8'h01, 8'h00, 8'h00, 7'd0, 1'b1, 1'b0, 7'd2},
      '{ROW_ITEM, MODE_QUERY, 8'h00, 8'h80, 8'h00, 7'd0, 1'b1, 1'b0, 7'd2},
      // duplicate add takes a slot of its own
      '{ROW_ITEM, MODE_ADD,   8'h00, 8'h00, 8'h00, 7'd0, 1'b1, 1'b0, 7'd3},
      '{ROW_ITEM, MODE_ADD,   8'hA5, 8'h5A, 8'hC3, 7'd0, 1'b1, 1'b0, 7'd4},
      '{ROW_ITEM, MODE_QUERY, 8'hA5, 8'h5A, 8'hC3, 7'd0, 1'b1, 1'b1, 7'd4},
      '{ROW_ITEM, MODE_QUERY, 8'h5A, 8'hA5, 8'h3C, 7'd0, 1'b1, 1'b0, 7'd4},
      // capacity zero counts as one, the next add drops everything older
      '{ROW_CAPACITY, MODE_QUERY, 8'h00, 8'h00, 8'h00, 7'd0, 1'b0, 1'b0, 7'd0},
      '{ROW_ITEM, MODE_ADD,   8'h12, 8'h34, 8'h56, 7'd0, 1'b1, 1'b0, 7'd1},
      '{ROW_ITEM, MODE_QUERY, 8'h00, 8'h00, 8'h00, 7'd0, 1'b1, 1'b0, 7'd1},
      '{ROW_ITEM, MODE_QUERY, 8'h12, 8'h34, 8'h56, 7'd0, 1'b1, 1'b1, 7'd1},
      '{ROW_ITEM, MODE_ADD,   8'h12, 8'h34, 8'h57, 7'd0, 1'b1, 1'b0, 7'd1},
      '{ROW_ITEM, MODE_QUERY, 8'h12, 8'h34, 8'h56, 7'd0, 1'b1, 1'b0, 7'd1},
      // capacity above the depth saturates
      '{ROW_CAPACITY, MODE_QUERY, 8'h00, 8'h00, 8'h00, 7'd127, 1'b0, 1'b0, 7'd0},
      '{ROW_ITEM, MODE_ADD,   8'h00, 8'h00, 8'h00, 7'd0, 1'b1, 1'b0, 7'd2},
      '{ROW_ITEM, MODE_QUERY, 8'h12, 8'h34, 8'h57, 7'd0, 1'b1, 1'b1, 7'd2},
      // full at two: the oldest goes on the next add
      '{ROW_CAPACITY, MODE_QUERY, 8'h00, 8'h00, 8'h00, 7'd2, 1'b0, 1'b0, 7'd0},
      '{ROW_ITEM, MODE_ADD,   8'h01, 8'h01, 8'h01, 7'd0, 1'b1, 1'b0, 7'd2},
      '{ROW_ITEM, MODE_QUERY, 8'h12, 8'h34, 8'h57, 7'd0, 1'b1, 1'b0, 7'd2},
      '{ROW_ITEM, MODE_QUERY, 8'h00, 8'h00, 8'h00, 7'd0, 1'b1, 1'b1, 7'd2},
      '{ROW_ITEM, MODE_QUERY, 8'h01, 8'h01, 8'h01, 7'd0, 1'b0, 1'b0, 7'd0}
   };

   // random phases: capacity, items, percentage of adds
   localparam int PHASES = 8;
   localparam int PHASE_CAP   [PHASES] = '{16, 127, 3, 0, 64, 5, 1, RANDOM_CAP};
   localparam int PHASE_ITEMS [PHASES] = '{60, 130, 40, 40, 110, 40, 30, 100};
   localparam int PHASE_ADDS  [PHASES] = '{60, 70, 40, 50, 65, 50, 50, 50};

   logic clock;
   logic reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   ttu_req_if req_ch ();
   ttu_rsp_if rsp_ch ();

   tabu_triple_table_unit i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // predicted table contents and capacity
   logic [KEY_W-1:0] slots [DEPTH];
   int               held;
   int               oldest;
   logic [CAP_W-1:0] cap_reg;

   outcome_type      answer_q [$];
   pinned_type       typed_q [$];
   logic [KEY_W-1:0] recent_keys [$];

   int fail_count;
   int n_adds;
   int n_queries;
   int n_hits;
   int n_cap_writes;
   int peak_fill;
   int req_run;
   int rsp_run;

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // table answer for one accepted beat, advancing the predicted state
   function automatic outcome_type tabu_answer(input logic mode, input logic [KEY_W-1:0] key);
      outcome_type ans;
      int          limit;
      int          drop;
      ans.hit = 1'b0;
      if (mode == MODE_ADD) begin
         limit = (cap_reg == 0) ? 1 : (int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg);
         if (held >= limit) begin
            drop   = held - limit + 1;
            oldest = (oldest + drop) % DEPTH;
            held   = held - drop;
         end
         slots[(oldest + held) % DEPTH] = key;
         held = held + 1;
      end else begin
         for (int i = 0; i < held; i++) begin
            if (slots[(oldest + i) % DEPTH] == key) ans.hit = 1'b1;
         end
      end
      ans.fill = FILL_W'(held);
      return ans;
   endfunction

   // idle cycles before the next beat, with occasional stretches of none
   function automatic int draw_pause(inout int run_left);
      if (run_left > 0) begin
         run_left--;
         return 0;
      end
      if ($urandom_range(19) == 0) begin
         run_left = $urandom_range(30, 8);
         return 0;
      end
      return $urandom_range(8);
   endfunction

   // triple for a random beat: queries mostly recent adds, some near misses and noise; adds mostly noise
   function automatic logic [KEY_W-1:0] pick_key(input logic mode);
      logic [KEY_W-1:0] key;
      int               roll;
      roll = $urandom_range(99);
      key  = KEY_W'($urandom());
      if (recent_keys.size() != 0) begin
         if (mode == MODE_QUERY && roll < 60)
            key = recent_keys[$urandom_range(recent_keys.size() - 1)];
         else if (mode == MODE_QUERY && roll < 75)
            key = recent_keys[$urandom_range(recent_keys.size() - 1)]
                  ^ (KEY_W'(1) << $urandom_range(KEY_W - 1));
         else if (mode == MODE_ADD && roll < 20)
            key = recent_keys[$urandom_range(recent_keys.size() - 1)];
      end
      return key;
   endfunction

   // one request beat, held until the unit takes it
   task automatic send_item(input logic mode, input logic [KEY_W-1:0] key,
                            input logic typed, input outcome_type val);
      int gap;
      gap = draw_pause(req_run);
      @(negedge clock);
      if (gap != 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      typed_q.push_back(pinned_type'{typed, val});
      if (mode == MODE_ADD) begin
         recent_keys.push_back(key);
         if (recent_keys.size() > RECENT_MAX) recent_keys.delete(0);
      end
      req_ch.mode           = mode;
      req_ch.job_index      = key[23:16];
      req_ch.op_order       = key[15:8];
      req_ch.resource_index = key[7:0];
      req_ch.valid          = 1'b1;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
   endtask

   // stop sending and wait until every answer is in
   task automatic drain;
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (answer_q.size() != 0) @(negedge clock);
   endtask

   // register write: setup cycle, then access cycle
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = addr;
      pwdata  = data;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (addr == CAP_ADDR) cap_reg = data[CAP_W-1:0];
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   // new capacity with noise in the unused bits, a write to the spare address, readback
   task automatic set_capacity(input logic [CAP_W-1:0] value);
      logic [CSR_DATA_W-1:0] data;
      drain();
      data = $urandom();
      data[CAP_W-1:0] = value;
      csr_write(CAP_ADDR, data);
      csr_write(SPARE_ADDR, $urandom());
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = CAP_ADDR;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata !== CSR_DATA_W'(cap_reg)) begin
         $error("capacity readback mismatch: expected %0d, got %0d", cap_reg, prdata);
         fail_count++;
      end
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      n_cap_writes++;
   endtask

   // request monitor: predict the answer of each accepted beat
   always @(posedge clock) begin
      pinned_type  pin;
      outcome_type ans;
      if (!reset && req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
         pin = typed_q[0];
         typed_q.delete(0);
         ans = tabu_answer(req_ch.mode,
                           {req_ch.job_index, req_ch.op_order, req_ch.resource_index});
         answer_q.push_back(pin.typed ? pin.val : ans);
         if (req_ch.mode == MODE_ADD) n_adds++;
         else n_queries++;
         if (held > peak_fill) peak_fill = held;
      end
   end

   // response monitor: compare each beat with the oldest answer
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (answer_q.size() == 0) begin
            $error("response beat with no answer waiting");
            fail_count++;
         end else begin
            want = answer_q[0];
            answer_q.delete(0);
            if (rsp_ch.hit !== want.hit) begin
               $error("hit mismatch: expected %0d, got %0d", want.hit, rsp_ch.hit);
               fail_count++;
            end
            if (rsp_ch.fill_count !== want.fill) begin
               $error("fill_count mismatch: expected %0d, got %0d",
                      want.fill, rsp_ch.fill_count);
               fail_count++;
            end
            if (rsp_ch.hit === 1'b1) n_hits++;
         end
      end
   end

   // response side back-pressure
   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         gap = draw_pause(rsp_run);
         if (gap != 0) begin
            rsp_ch.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1 || reset);
      end
   end

   // watchdog on cycles without any accepted beat
   initial begin
      int stall;
      stall = 0;
      while (stall < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
             (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            stall = 0;
         else
            stall++;
      end
      $display("timeout: no beat accepted for %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   // stimulus
   initial begin
      logic             mode;
      logic [CAP_W-1:0] cap;
      reset                 = 1'b1;
      psel                  = 1'b0;
      penable               = 1'b0;
      pwrite                = 1'b0;
      paddr                 = '0;
      pwdata                = '0;
      req_ch.valid          = 1'b0;
      req_ch.mode           = MODE_QUERY;
      req_ch.job_index      = '0;
      req_ch.op_order       = '0;
      req_ch.resource_index = '0;
      held                  = 0;
      oldest                = 0;
      cap_reg               = CAP_RESET;
      fail_count            = 0;
      n_adds                = 0;
      n_queries             = 0;
      n_hits                = 0;
      n_cap_writes          = 0;
      peak_fill             = 0;
      req_run               = 0;
      rsp_run               = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed rows
      foreach (DIRECTED[r]) begin
         if (DIRECTED[r].kind == ROW_CAPACITY)
            set_capacity(DIRECTED[r].cap);
         else
            send_item(DIRECTED[r].mode, {DIRECTED[r].job, DIRECTED[r].ord, DIRECTED[r].res},
                      DIRECTED[r].typed, outcome_type'{DIRECTED[r].hit, DIRECTED[r].fill});
      end

      // random phases, each under its own capacity
      for (int p = 0; p < PHASES; p++) begin
         cap = (PHASE_CAP[p] == RANDOM_CAP) ? CAP_W'($urandom_range(127))
                                            : CAP_W'(PHASE_CAP[p]);
         set_capacity(cap);
         for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
            mode = ($urandom_range(99) < PHASE_ADDS[p]) ? MODE_ADD : MODE_QUERY;
            send_item(mode, pick_key(mode), 1'b0, '0);
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d adds and %0d queries (%0d hits) under %0d capacity writes",
               n_adds, n_queries, n_hits, n_cap_writes);
      $display("fill count peaked at %0d, with wrap-round, eviction and lowered capacity",
               peak_fill);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
